>>> hw/rtl/sld_pkg.sv
`timescale 1ns / 1ps
package sld_pkg;

  // frame header layout
  localparam int unsigned HEADER_LEN  = 5;
  localparam int unsigned OFS_SYNC2   = 1;
  localparam int unsigned OFS_LEN_LO  = 3;
  localparam int unsigned OFS_LEN_HI  = 4;

  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;

  // a completed frame never exceeds 64 bytes
  localparam int unsigned NEED_W = 7;
  localparam int unsigned POS_W  = 6;

  // finished frames waiting for readout, one per buffer bank
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic              bank;
    logic [NEED_W-1:0] need;
  } desc_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_SHOW
  } back_state_e;

endpackage

>>> hw/rtl/sld_ram.sv
`timescale 1ns / 1ps
module sld_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/sld_front.sv
`timescale 1ns / 1ps
module sld_front #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [7:0]                        byte_i,
  output logic                              ready_o,
  input  sld_pkg::queue_status_t            qstat_i,
  output logic                              push_o,
  output sld_pkg::desc_t                    desc_o,
  output logic                              we_o,
  output logic [$clog2(BUFFER_DEPTH):0]     waddr_o,
  output logic [7:0]                        wdata_o,
  output logic                              bank_o
);

  localparam int unsigned CNT_W  = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(BUFFER_DEPTH);

  logic [CNT_W-1:0]  fill_q, fill_d;
  logic              bank_q, bank_d;
  logic              sync2_ok_q, sync2_ok_d;
  logic [7:0]        len_lo_q, len_lo_d;
  logic [7:0]        len_hi_q, len_hi_d;

  logic              accept;
  logic [ADDR_W-1:0] off;
  logic [CNT_W-1:0]  cnt_new;
  logic [7:0]        len_hi;
  logic [16:0]       need;

  assign ready_o = !qstat_i.full;
  assign accept  = valid_i && ready_o;

  always_comb begin
    // a full buffer wraps, the new byte lands at offset zero
    off     = (fill_q >= CNT_W'(BUFFER_DEPTH)) ? '0 : fill_q[ADDR_W-1:0];
    cnt_new = CNT_W'(off) + CNT_W'(1);
    len_hi  = (off == ADDR_W'(sld_pkg::OFS_LEN_HI)) ? byte_i : len_hi_q;
    need    = 17'(sld_pkg::HEADER_LEN) + 17'({len_hi, len_lo_q});

    fill_d     = fill_q;
    bank_d     = bank_q;
    sync2_ok_d = sync2_ok_q;
    len_lo_d   = len_lo_q;
    len_hi_d   = len_hi_q;
    push_o     = 1'b0;
    desc_o     = '{bank: bank_q, need: need[sld_pkg::NEED_W-1:0]};

    if (accept) begin
      if (off == ADDR_W'(sld_pkg::OFS_SYNC2)) begin
        sync2_ok_d = (byte_i == sld_pkg::SYNC_SECOND);
      end
      if (off == ADDR_W'(sld_pkg::OFS_LEN_LO)) begin
        len_lo_d = byte_i;
      end
      if (off == ADDR_W'(sld_pkg::OFS_LEN_HI)) begin
        len_hi_d = byte_i;
      end

      if (off == '0 && byte_i != sld_pkg::SYNC_FIRST) begin
        fill_d = '0;
      end else if (cnt_new < CNT_W'(sld_pkg::HEADER_LEN)) begin
        fill_d = cnt_new;
      end else if (cnt_new == CNT_W'(sld_pkg::HEADER_LEN) && !sync2_ok_q) begin
        fill_d = '0;
      end else if (17'(cnt_new) == need) begin
        push_o = 1'b1;
        fill_d = '0;
        bank_d = !bank_q;
      end else begin
        fill_d = cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      bank_q     <= 1'b0;
      sync2_ok_q <= 1'b0;
    end else begin
      fill_q     <= fill_d;
      bank_q     <= bank_d;
      sync2_ok_q <= sync2_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_lo_q <= len_lo_d;
    len_hi_q <= len_hi_d;
  end

  assign we_o    = accept;
  assign waddr_o = {bank_q, off};
  assign wdata_o = byte_i;
  assign bank_o  = bank_q;

endmodule

>>> hw/rtl/sld_fifo.sv
`timescale 1ns / 1ps
module sld_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  sld_pkg::desc_t         desc_i,
  input  logic                   pop_i,
  output sld_pkg::desc_t         head_o,
  output sld_pkg::queue_status_t status_o
);

  localparam int unsigned PTR_W = $clog2(sld_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(sld_pkg::QUEUE_DEPTH + 1);

  sld_pkg::desc_t   entry_q [sld_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign head_o         = entry_q[rd_ptr_q];
  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == CNT_W'(sld_pkg::QUEUE_DEPTH));

endmodule

>>> hw/rtl/sld_back.sv
`timescale 1ns / 1ps
module sld_back #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sld_pkg::queue_status_t        qstat_i,
  input  sld_pkg::desc_t                head_i,
  output logic                          pop_o,
  output logic                          re_o,
  output logic [$clog2(BUFFER_DEPTH):0] raddr_o,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [sld_pkg::POS_W-1:0]     position_o,
  output logic                          end_o,
  output logic                          busy_o
);

  localparam int unsigned ADDR_W = $clog2(BUFFER_DEPTH);

  sld_pkg::back_state_e        state_q, state_d;
  logic [sld_pkg::POS_W-1:0]   idx_q, idx_d;
  logic                        last;

  assign last = ((sld_pkg::NEED_W'(idx_q) + sld_pkg::NEED_W'(1)) == head_i.need);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    pop_o   = 1'b0;
    re_o    = 1'b0;
    valid_o = 1'b0;
    case (state_q)
      sld_pkg::BK_IDLE: begin
        idx_d = '0;
        if (!qstat_i.empty) begin
          state_d = sld_pkg::BK_FETCH;
        end
      end
      sld_pkg::BK_FETCH: begin
        re_o    = 1'b1;
        state_d = sld_pkg::BK_SHOW;
      end
      sld_pkg::BK_SHOW: begin
        valid_o = 1'b1;
        if (ready_i) begin
          if (last) begin
            pop_o   = 1'b1;
            idx_d   = '0;
            state_d = sld_pkg::BK_IDLE;
          end else begin
            idx_d   = idx_q + sld_pkg::POS_W'(1);
            state_d = sld_pkg::BK_FETCH;
          end
        end
      end
      default: begin
        state_d = sld_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sld_pkg::BK_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign raddr_o    = {head_i.bank, idx_q[ADDR_W-1:0]};
  assign position_o = idx_q;
  assign end_o      = last;
  assign busy_o     = (state_q != sld_pkg::BK_IDLE);

endmodule

>>> hw/rtl/sync_length_frame_deframer_unit.sv
`timescale 1ns / 1ps
// Sync-word, length-prefixed frame deframer. Serial bytes enter one per transfer on the rx
// channel and are stored in a two-bank frame buffer. A frame is 0x55, 0xAA, a command byte,
// a little-endian 16-bit payload length and then the payload; a bad first byte or a bad
// second byte (checked once the header is in) drops the partial frame, and a buffer that
// fills before the frame completes wraps back to offset zero. A completed frame is read back
// and sent on the frame channel one byte per transfer with its offset and a last mark. Each
// frame byte is read from the registered RAM (BK_FETCH) and then presented (BK_SHOW), where it
// holds until frame_ready_i takes it; readout passes through idle between frames. One
// finished frame can drain from one bank while the next frame is received into the other;
// with both banks pending, rx_ready_o stays low until the older frame has fully left. The
// buffer needs no clearing after reset.
module sync_length_frame_deframer_unit #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // received bytes
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  // completed frame bytes
  output logic       frame_valid_o,
  input  logic       frame_ready_i,
  output logic [7:0] frame_byte_o,
  output logic [5:0] byte_position_o,
  output logic       frame_end_o
);

  localparam int unsigned ADDR_W   = $clog2(BUFFER_DEPTH);
  localparam int unsigned RAM_DEPTH = 2 * (2 ** ADDR_W);

  // front to queue and buffer
  logic                   push;
  sld_pkg::desc_t         push_desc;
  logic                   wr_en;
  logic [ADDR_W:0]        wr_addr;
  logic [7:0]             wr_data;
  logic                   wr_bank;

  // queue to back
  sld_pkg::desc_t         head;
  sld_pkg::queue_status_t qstat;
  logic                   pop;

  // back to buffer
  logic                   rd_en;
  logic [ADDR_W:0]        rd_addr;
  logic                   back_busy;

  // front: stores bytes, tracks the header, flags complete frames
  sld_front #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rx_valid_i),
    .byte_i  (rx_byte_i),
    .ready_o (rx_ready_o),
    .qstat_i (qstat),
    .push_o  (push),
    .desc_o  (push_desc),
    .we_o    (wr_en),
    .waddr_o (wr_addr),
    .wdata_o (wr_data),
    .bank_o  (wr_bank)
  );

  // frame buffer, one bank being filled while the other drains
  sld_ram #(
    .WIDTH(8),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (frame_byte_o)
  );

  // completed frames waiting for readout
  sld_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .desc_i   (push_desc),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (qstat)
  );

  // back: walks the oldest completed frame out of the buffer
  sld_back #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .qstat_i    (qstat),
    .head_i     (head),
    .pop_o      (pop),
    .re_o       (rd_en),
    .raddr_o    (rd_addr),
    .valid_o    (frame_valid_o),
    .ready_i    (frame_ready_i),
    .position_o (byte_position_o),
    .end_o      (frame_end_o),
    .busy_o     (back_busy)
  );

  // readout only runs on a queued frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_busy |-> !qstat.empty)
    else $error("readout active with no queued frame");

  // a byte is never written into the bank being read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && back_busy) |-> (wr_bank != head.bank))
    else $error("fill bank collides with readout bank");

  // the last byte of a frame releases its queue entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_valid_o && frame_ready_i && frame_end_o) |-> pop)
    else $error("frame end transfer without queue release");

  // a frame is queued only while the queue has room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full)
    else $error("frame queued while queue full");

endmodule

>>> tb/sv/tb_sync_length_frame_deframer_unit.sv
`timescale 1ns / 1ps
module tb_sync_length_frame_deframer_unit;

  localparam int unsigned BUFFER_DEPTH = 64;
  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned PHASE_ITEMS  = 70;
  localparam int unsigned SETTLE       = 300;
  // a script row with this count is checked only through the mirror model
  localparam int          UNCHECKED    = -1;

  // one byte of a completed frame as it should leave the block
  typedef struct packed {
    logic [7:0]                data;
    logic [sld_pkg::POS_W-1:0] pos;
    logic                      last;
  } frame_beat_t;

  // one directed byte and the number of frame bytes it releases
  typedef struct packed {
    logic [7:0] rx;
    int         emits;
  } script_row_t;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       rx_valid_i      = 1'b0;
  logic       rx_ready_o;
  logic [7:0] rx_byte_i       = 8'h00;
  logic       frame_valid_o;
  logic       frame_ready_i   = 1'b0;
  logic [7:0] frame_byte_o;
  logic [5:0] byte_position_o;
  logic       frame_end_o;

  // mirror of the frame buffer and its fill count
  logic [7:0]  mirror_buf [BUFFER_DEPTH];
  int unsigned mirror_fill;

  // frame bytes released by the mirror and not yet seen on the frame channel
  frame_beat_t frame_due [$];

  int unsigned mismatch_count  = 0;
  int unsigned rx_accepted     = 0;
  int          last_emit_count = 0;
  int unsigned cycle_count     = 0;

  // traffic shaping, changed by the main sequence between phases
  int unsigned send_idle_pct   = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned hold_cycles_req = 0;

  // directed part: sync errors, the shortest frame, a bad second sync byte
  // that only counts once the header is in, and a frame with extreme bytes
  script_row_t script [18] = '{
    '{8'h00,                0},          // bad first byte, all zeros
    '{8'hFF,                0},          // bad first byte, all ones
    '{sld_pkg::SYNC_FIRST,  0},          // empty payload frame
    '{sld_pkg::SYNC_SECOND, UNCHECKED},
    '{8'h00,                UNCHECKED},
    '{8'h00,                UNCHECKED},
    '{8'h00,                5},          // header alone completes the frame
    '{sld_pkg::SYNC_FIRST,  0},          // second sync byte wrong
    '{sld_pkg::SYNC_FIRST,  0},          // short header holds, nothing dropped yet
    '{8'h01,                0},
    '{8'h00,                0},
    '{8'h00,                0},          // header in, bad second byte drops it
    '{sld_pkg::SYNC_FIRST,  0},          // one byte payload, extreme values
    '{sld_pkg::SYNC_SECOND, UNCHECKED},
    '{8'hFF,                UNCHECKED},
    '{8'h01,                UNCHECKED},
    '{8'h00,                UNCHECKED},
    '{8'hFF,                6}
  };

  sync_length_frame_deframer_unit #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_valid_i      (rx_valid_i),
    .rx_ready_o      (rx_ready_o),
    .rx_byte_i       (rx_byte_i),
    .frame_valid_o   (frame_valid_o),
    .frame_ready_i   (frame_ready_i),
    .frame_byte_o    (frame_byte_o),
    .byte_position_o (byte_position_o),
    .frame_end_o     (frame_end_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // run limit, far above the slowest legal run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // mirror of the deframer: store one byte, return how many frame bytes it releases
  function automatic int deframe_byte(input logic [7:0] b);
    int unsigned need;
    // a full buffer wraps, losing any partial frame
    if (mirror_fill >= BUFFER_DEPTH) mirror_fill = 0;
    mirror_buf[mirror_fill] = b;
    mirror_fill++;
    if (mirror_buf[0] != sld_pkg::SYNC_FIRST) begin
      mirror_fill = 0;
      return 0;
    end
    if (mirror_fill < sld_pkg::HEADER_LEN) return 0;
    if (mirror_buf[sld_pkg::OFS_SYNC2] != sld_pkg::SYNC_SECOND) begin
      mirror_fill = 0;
      return 0;
    end
    need = sld_pkg::HEADER_LEN
         + {mirror_buf[sld_pkg::OFS_LEN_HI], mirror_buf[sld_pkg::OFS_LEN_LO]};
    if (mirror_fill < need) return 0;
    // whole frame, header included, leaves in order
    for (int unsigned i = 0; i < need; i++) begin
      frame_due.push_back('{data: mirror_buf[i], pos: sld_pkg::POS_W'(i),
                            last: (i + 1 == need)});
    end
    mirror_fill = 0;
    return int'(need);
  endfunction

  // offer one byte on the rx channel, starting and ending at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!rx_ready_o);
    last_emit_count = deframe_byte(b);
    rx_accepted++;
    @(negedge clk_i);
  endtask

  // sync bytes, command, length, then n_body payload bytes (may be fewer than length)
  task automatic send_frame(input logic [7:0] sync2, input logic [15:0] len,
                            input int unsigned n_body);
    send_byte(sld_pkg::SYNC_FIRST);
    send_byte(sync2);
    send_byte(8'($urandom_range(255)));
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    repeat (n_body) send_byte(8'($urandom_range(255)));
  endtask

  // sender goes quiet until every released frame byte has come out
  task automatic pause_until_drained();
    rx_valid_i <= 1'b0;
    do @(negedge clk_i); while (frame_due.size() != 0);
  endtask

  // one random stretch of traffic, mostly well-formed frames
  task automatic send_random_sequence();
    int unsigned pick;
    int unsigned len;
    logic [7:0]  sync2;
    pick = $urandom_range(99);
    if (pick < 70) begin
      // good frame, mostly short, now and then up to the buffer size
      len = ($urandom_range(9) == 0) ? $urandom_range(BUFFER_DEPTH - sld_pkg::HEADER_LEN)
                                     : $urandom_range(8);
      send_frame(sld_pkg::SYNC_SECOND, 16'(len), len);
    end else if (pick < 78) begin
      sync2 = 8'($urandom_range(255));
      if (sync2 == sld_pkg::SYNC_SECOND) sync2 = 8'h2A;
      send_frame(sync2, 16'($urandom_range(6)), $urandom_range(6));
    end else if (pick < 86) begin
      // frame cut short, the next bytes run into it
      len = 4 + $urandom_range(8);
      send_frame(sld_pkg::SYNC_SECOND, 16'(len), $urandom_range(len - 1));
    end else if (pick < 97) begin
      repeat (1 + $urandom_range(3)) send_byte(8'($urandom_range(255)));
    end else begin
      // longer than the buffer: fills it exactly, the next byte wraps
      send_frame(sld_pkg::SYNC_SECOND,
                 16'(BUFFER_DEPTH - sld_pkg::HEADER_LEN + 1 + $urandom_range(65000)),
                 BUFFER_DEPTH - sld_pkg::HEADER_LEN);
    end
  endtask

  // frame channel ready: random stalls, or a long hold-off when requested
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_cycles_req != 0) begin
        frame_ready_i <= 1'b0;
        for (int unsigned c = 0; c < hold_cycles_req; c++) @(negedge clk_i);
        hold_cycles_req = 0;
      end else begin
        frame_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // compare every frame transfer with the oldest released byte
  always @(posedge clk_i) begin
    frame_beat_t want;
    if (rst_ni && frame_valid_o && frame_ready_i) begin
      if (frame_due.size() == 0) begin
        $error("frame transfer with nothing due: byte %0h position %0d end %0b",
               frame_byte_o, byte_position_o, frame_end_o);
        mismatch_count++;
      end else begin
        want = frame_due.pop_front();
        if (frame_byte_o !== want.data) begin
          $error("frame_byte: expected %0h, got %0h", want.data, frame_byte_o);
          mismatch_count++;
        end
        if (byte_position_o !== want.pos) begin
          $error("byte_position: expected %0d, got %0d", want.pos, byte_position_o);
          mismatch_count++;
        end
        if (frame_end_o !== want.last) begin
          $error("frame_end: expected %0b, got %0b", want.last, frame_end_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int unsigned phase_start;
    mirror_fill = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed script, counts typed in where obvious
    foreach (script[r]) begin
      send_byte(script[r].rx);
      if (script[r].emits != UNCHECKED && last_emit_count != script[r].emits) begin
        $error("frame bytes released by row %0d: expected %0d, got %0d",
               r, script[r].emits, last_emit_count);
        mismatch_count++;
      end
    end
    pause_until_drained();

    // random phases: no idling, sender idle, receiver stalling, both
    for (int unsigned phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 75;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 75;
        end
        default: begin
          send_idle_pct  = 11;
          recv_stall_pct = 11;
        end
      endcase
      phase_start = rx_accepted;
      if (phase == 0) begin
        // receiver holds off while short frames keep coming: both banks
        // fill and the rx channel must back-pressure
        hold_cycles_req = HOLD_CYCLES;
        repeat (10) send_frame(sld_pkg::SYNC_SECOND, 16'($urandom_range(3)), 0);
        pause_until_drained();
        // largest frame that fits, then one that overruns the buffer
        send_frame(sld_pkg::SYNC_SECOND, 16'(BUFFER_DEPTH - sld_pkg::HEADER_LEN),
                   BUFFER_DEPTH - sld_pkg::HEADER_LEN);
        send_frame(sld_pkg::SYNC_SECOND, 16'h0100, BUFFER_DEPTH - sld_pkg::HEADER_LEN);
        send_frame(sld_pkg::SYNC_SECOND, 16'($urandom_range(4)), 0);
      end
      while (rx_accepted - phase_start < PHASE_ITEMS) send_random_sequence();
      pause_until_drained();
    end

    // let anything stray show up before the verdict
    recv_stall_pct = 0;
    repeat (SETTLE) @(posedge clk_i);
    if (mismatch_count == 0 && frame_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
